[sv/lpdf_pkg.sv]
// Package for the length-prefixed deframer: request kinds, parse phases,
// status codes, configuration defaults and the shared item/record types.
// No dependencies.
package lpdf_pkg;

    localparam int CONN_W     = 6;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 32;
    localparam int COUNT_W    = 17;
    localparam int PHASE_W    = 3;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;
    localparam int KIND_W     = 2;
    localparam int LIMIT_W    = 16;
    localparam int MAXMSG_W   = 25;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // request types on the input stream
    localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OPEN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;

    // classified work handed to the back end
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOSLOT = 2'd3;

    localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LONG0   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LONG1   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LONG2   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LONG3   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd6;
    localparam logic [PHASE_W-1:0] PH_LOCKED  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LONG_SMALL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERLOAD   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_OPEN   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXMSG = 2'd2;

    localparam logic [BYTE_W-1:0]  LEN_ESCAPE = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;

    localparam logic [TIME_W-1:0]   RST_WINDOW = 32'd5000;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 16'd250;
    localparam logic [MAXMSG_W-1:0] RST_MAXMSG = 25'd65536;

    typedef struct packed {
        logic [TIME_W-1:0]   window_ms;
        logic [LIMIT_W-1:0]  limit_count;
        logic [MAXMSG_W-1:0] max_msg;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CONN_W-1:0] conn;
        logic [BYTE_W-1:0] data;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEN_W-1:0]   remaining;
        logic [TIME_W-1:0]  win_start;
        logic [COUNT_W-1:0] count;
    } t_rec;

endpackage

[sv/length_prefixed_deframer_rate_limit_top.sv]
// Length-prefixed deframer with per-connection rate limit, top level.
// Throughput: one request per cycle sustained while the output is not stalled. An
// accepted request is written to the queue, popped with the record memory read,
// then updated into the output reg. Rate is set by the per-item RMW.
// Reset (synchronous, active low): config to defaults, then a clearing pass over
// the record memory closes every slot; s_axis_tready stays low until it ends.
module length_prefixed_deframer_rate_limit_top #(
    parameter int CONNECTIONS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] conn, [13:6] data_byte, [45:14] now_ms, [47:46] zero
    input  logic [lpdf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [lpdf_pkg::REQ_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] out_conn, [13:6] payload_byte
    output logic [lpdf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    // [2:0] status
    output logic [lpdf_pkg::STATUS_W-1:0]      m_axis_tuser,
    input  logic                               i_cfg_we,
    input  logic [lpdf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpdf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lpdf_pkg::*;

    t_cfg              r_cfg;
    logic              w_clr_done;
    logic              w_q_ready;
    logic              w_push;
    t_item             w_push_item;
    logic              w_pop;
    logic              w_head_valid;
    t_item             w_head;
    logic [CONN_W-1:0] w_out_conn;
    logic [BYTE_W-1:0] w_out_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms   <= RST_WINDOW;
            r_cfg.limit_count <= RST_LIMIT;
            r_cfg.max_msg     <= RST_MAXMSG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW: r_cfg.window_ms   <= i_cfg_data[TIME_W-1:0];
                CFG_LIMIT:  r_cfg.limit_count <= i_cfg_data[LIMIT_W-1:0];
                CFG_MAXMSG: r_cfg.max_msg     <= i_cfg_data[MAXMSG_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    lpdf_front #(
        .CONNECTIONS (CONNECTIONS)
    ) u_front (
        .i_enable      (w_clr_done),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_ready     (w_q_ready),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    lpdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    lpdf_back #(
        .CONNECTIONS (CONNECTIONS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_clr_done   (w_clr_done),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_conn   (w_out_conn),
        .o_out_byte   (w_out_byte),
        .o_out_last   (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_DATA_W'({w_out_byte, w_out_conn});

endmodule

[sv/lpdf_front.sv]
// Front end: takes requests from the input stream and classifies them.
// Depends on lpdf_pkg; feeds lpdf_queue.
module lpdf_front #(
    parameter int CONNECTIONS = 64
) (
    input  logic                          i_enable,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [5:0] conn, [13:6] data_byte, [45:14] now_ms, [47:46] zero
    input  logic [lpdf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [lpdf_pkg::REQ_W-1:0]    s_axis_tuser,
    input  logic                          i_q_ready,
    output logic                          o_push,
    output lpdf_pkg::t_item               o_item
);
    import lpdf_pkg::*;

    logic              w_fire;
    logic              w_slot_ok;
    logic              w_keep;
    logic [CONN_W-1:0] w_conn;

    assign s_axis_tready = i_enable & i_q_ready;
    assign w_fire        = s_axis_tvalid & s_axis_tready;
    assign w_conn        = s_axis_tdata[CONN_W-1:0];
    assign w_slot_ok     = (32'(w_conn) < CONNECTIONS);

    // open/close on a missing slot and the unused request type do nothing
    always_comb begin
        o_item.conn = w_conn;
        o_item.data = s_axis_tdata[CONN_W +: BYTE_W];
        o_item.now  = s_axis_tdata[CONN_W+BYTE_W +: TIME_W];
        o_item.kind = KIND_BYTE;
        w_keep      = 1'b0;
        case (s_axis_tuser)
            REQ_BYTE: begin
                w_keep      = 1'b1;
                o_item.kind = w_slot_ok ? KIND_BYTE : KIND_NOSLOT;
            end
            REQ_OPEN: begin
                w_keep      = w_slot_ok;
                o_item.kind = KIND_OPEN;
            end
            REQ_CLOSE: begin
                w_keep      = w_slot_ok;
                o_item.kind = KIND_CLOSE;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_push = w_fire & w_keep;

endmodule

[sv/lpdf_queue.sv]
// Short queue of classified requests between front and back end.
// Depends on lpdf_pkg.
module lpdf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpdf_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output lpdf_pkg::t_item o_head
);
    import lpdf_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push & o_ready;
    assign w_pop   = i_pop & o_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[sv/lpdf_back.sv]
// Back end: per-connection record memory, read-modify-write with forwarding
// of the last write, frame/rate logic and the output register.
// Depends on lpdf_pkg; fed by lpdf_queue.
module lpdf_back #(
    parameter int CONNECTIONS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpdf_pkg::t_cfg              i_cfg,
    input  logic                        i_head_valid,
    input  lpdf_pkg::t_item             i_head,
    output logic                        o_pop,
    output logic                        o_clr_done,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lpdf_pkg::CONN_W-1:0] o_out_conn,
    output logic [lpdf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_last,
    output logic [lpdf_pkg::STATUS_W-1:0] o_out_status
);
    import lpdf_pkg::*;

    localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

    t_rec                r_mem [CONNECTIONS];
    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_idx;
    logic                r_b_valid;
    t_item               r_b_item;
    t_rec                r_rd;
    logic                r_lw_valid;
    logic [AW-1:0]       r_lw_addr;
    t_rec                r_lw_rec;
    logic                r_out_valid;
    logic [CONN_W-1:0]   r_out_conn;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;
    logic [STATUS_W-1:0] r_out_status;

    logic [AW+CONN_W-1:0] w_head_ext;
    logic [AW+CONN_W-1:0] w_b_ext;
    logic [AW-1:0]        w_head_addr;
    logic [AW-1:0]        w_b_addr;
    logic                 w_b_fire;
    t_rec                 w_cur;
    t_rec                 n_rec;
    logic                 w_we;
    logic                 w_res;
    logic [BYTE_W-1:0]    w_res_byte;
    logic                 w_res_last;
    logic [STATUS_W-1:0]  w_res_status;
    logic [1:0]           w_k;
    logic [LEN_W-1:0]     w_len;
    logic [COUNT_W-1:0]   w_cnt_inc;
    logic [TIME_W-1:0]    w_elapsed;

    assign w_head_ext  = {{AW{1'b0}}, i_head.conn};
    assign w_b_ext     = {{AW{1'b0}}, r_b_item.conn};
    assign w_head_addr = w_head_ext[AW-1:0];
    assign w_b_addr    = w_b_ext[AW-1:0];

    assign w_b_fire = r_b_valid & (~r_out_valid | i_out_ready);
    assign o_pop    = ~r_clr_busy & i_head_valid & (~r_b_valid | w_b_fire);
    assign o_clr_done = ~r_clr_busy;

    // the read for this item may have missed the write of the item before it
    assign w_cur = (r_lw_valid && r_lw_addr == w_b_addr) ? r_lw_rec : r_rd;

    assign w_k       = 2'(w_cur.phase - PH_LONG0);
    assign w_len     = w_cur.remaining | (LEN_W'(r_b_item.data) << {w_k, 3'b000});
    assign w_cnt_inc = (w_cur.count != COUNT_MAX) ? w_cur.count + 1'b1 : w_cur.count;
    assign w_elapsed = r_b_item.now - w_cur.win_start;

    always_comb begin
        n_rec        = w_cur;
        w_we         = 1'b0;
        w_res        = 1'b0;
        w_res_byte   = '0;
        w_res_last   = 1'b1;
        w_res_status = ST_OK;
        case (r_b_item.kind)
            KIND_OPEN: begin
                w_we            = 1'b1;
                n_rec.phase     = PH_LEN;
                n_rec.remaining = '0;
                n_rec.win_start = r_b_item.now;
                n_rec.count     = '0;
            end
            KIND_CLOSE: begin
                w_we            = 1'b1;
                n_rec.phase     = PH_CLOSED;
                n_rec.win_start = '0;
                n_rec.count     = '0;
            end
            KIND_NOSLOT: begin
                w_res        = 1'b1;
                w_res_status = ST_NOT_OPEN;
            end
            KIND_BYTE: begin
                case (w_cur.phase)
                    PH_CLOSED: begin
                        w_res        = 1'b1;
                        w_res_status = ST_NOT_OPEN;
                    end
                    PH_LEN: begin
                        w_we = 1'b1;
                        if (r_b_item.data == LEN_ESCAPE) begin
                            n_rec.remaining = '0;
                            n_rec.phase     = PH_LONG0;
                        end else if (r_b_item.data < 8'd2) begin
                            n_rec.phase  = PH_LOCKED;
                            w_res        = 1'b1;
                            w_res_status = ST_SHORT;
                        end else begin
                            n_rec.remaining = LEN_W'(r_b_item.data);
                            n_rec.phase     = PH_PAYLOAD;
                        end
                    end
                    PH_LONG0, PH_LONG1, PH_LONG2, PH_LONG3: begin
                        w_we            = 1'b1;
                        n_rec.remaining = w_len;
                        if (w_cur.phase != PH_LONG3) begin
                            n_rec.phase = w_cur.phase + 1'b1;
                        end else if (w_len[LEN_W-1] || w_len < 32'd2) begin
                            n_rec.phase  = PH_LOCKED;
                            w_res        = 1'b1;
                            w_res_status = ST_LONG_SMALL;
                        end else if (w_len >= LEN_W'(i_cfg.max_msg)) begin
                            n_rec.phase  = PH_LOCKED;
                            w_res        = 1'b1;
                            w_res_status = ST_TOO_LARGE;
                        end else begin
                            n_rec.phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        w_we       = 1'b1;
                        w_res      = 1'b1;
                        w_res_byte = r_b_item.data;
                        if (w_cur.remaining <= 32'd1) begin
                            n_rec.remaining = '0;
                            n_rec.phase     = PH_LEN;
                            n_rec.count     = w_cnt_inc;
                            if (w_cnt_inc > COUNT_W'(i_cfg.limit_count)) begin
                                w_res_status = ST_OVERLOAD;
                            end else if (w_elapsed > i_cfg.window_ms) begin
                                n_rec.win_start = r_b_item.now;
                                n_rec.count     = '0;
                            end
                        end else begin
                            n_rec.remaining = w_cur.remaining - 1'b1;
                            w_res_last      = 1'b0;
                        end
                    end
                    default: begin
                        // locked: byte dropped
                        w_we = 1'b0;
                    end
                endcase
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_b_valid   <= 1'b0;
            r_lw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(CONNECTIONS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (w_b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_fire && w_we) begin
                r_lw_valid <= 1'b1;
            end
            if (w_b_fire) begin
                r_out_valid <= w_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_item <= i_head;
        end
        if (w_b_fire && w_we) begin
            r_lw_addr <= w_b_addr;
            r_lw_rec  <= n_rec;
        end
        if (w_b_fire && w_res) begin
            r_out_conn   <= r_b_item.conn;
            r_out_byte   <= w_res_byte;
            r_out_last   <= w_res_last;
            r_out_status <= w_res_status;
        end
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '{phase: PH_CLOSED, remaining: '0, win_start: '0, count: '0};
        end else if (w_b_fire && w_we) begin
            r_mem[w_b_addr] <= n_rec;
        end
        if (o_pop) begin
            r_rd <= r_mem[w_head_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_conn   = r_out_conn;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_pop)
        else $error("request taken during memory clear");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_fire && w_res) |=> r_out_valid)
        else $error("result lost at output register");

    a_out_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_b_fire && w_res))
        else $error("output valid without a processed request");

    a_forward_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_fire && w_we) |=> (r_lw_valid && r_lw_addr == $past(w_b_addr)))
        else $error("forwarding register missed a write");

endmodule

[tb/length_prefixed_deframer_rate_limit_top_tb.sv]
// Testbench for length_prefixed_deframer_rate_limit_top: mixed frames and
// connection requests are checked against a per-slot deframing model.
// Depends on lpdf_pkg and the top level RTL.
`timescale 1ns / 1ps

module length_prefixed_deframer_rate_limit_top_tb;

    import lpdf_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [CONN_W-1:0]   conn;
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_deframed_byte;

    class deframe_scoreboard;
        logic [PHASE_W-1:0]  phase     [64];
        logic [LEN_W-1:0]    remaining [64];
        logic [TIME_W-1:0]   win_start [64];
        logic [COUNT_W-1:0]  count     [64];
        logic [TIME_W-1:0]   window_ms;
        logic [LIMIT_W-1:0]  limit_count;
        logic [MAXMSG_W-1:0] max_msg;
        t_deframed_byte      due_bytes [$];
        int                  errors;

        function new();
            window_ms   = RST_WINDOW;
            limit_count = RST_LIMIT;
            max_msg     = RST_MAXMSG;
            errors      = 0;
            for (int i = 0; i < 64; i++) begin
                phase[i]     = PH_CLOSED;
                remaining[i] = '0;
                win_start[i] = '0;
                count[i]     = '0;
            end
        endfunction

        function void set_config(logic [TIME_W-1:0] win, logic [LIMIT_W-1:0] lim,
                                 logic [MAXMSG_W-1:0] maxm);
            window_ms   = win;
            limit_count = lim;
            max_msg     = maxm;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void expect_byte(logic [CONN_W-1:0] c, logic [BYTE_W-1:0] b, logic last,
                                  logic [STATUS_W-1:0] st);
            t_deframed_byte e;
            e.conn   = c;
            e.data   = b;
            e.last   = last;
            e.status = st;
            due_bytes = {due_bytes, e};
        endfunction

        // model update for one accepted request
        function void note_request(logic [REQ_W-1:0] req, logic [CONN_W-1:0] c,
                                   logic [BYTE_W-1:0] b, logic [TIME_W-1:0] now);
            logic [PHASE_W-1:0]  ph;
            logic [LEN_W-1:0]    len;
            logic [STATUS_W-1:0] st;
            int                  k;
            ph = phase[c];
            if (req == REQ_OPEN) begin
                phase[c]     = PH_LEN;
                remaining[c] = '0;
                win_start[c] = now;
                count[c]     = '0;
            end else if (req == REQ_CLOSE) begin
                phase[c]     = PH_CLOSED;
                win_start[c] = '0;
                count[c]     = '0;
            end else if (req == REQ_BYTE) begin
                if (ph == PH_CLOSED) begin
                    expect_byte(c, 8'd0, 1'b1, ST_NOT_OPEN);
                end else if (ph == PH_LEN) begin
                    if (b == LEN_ESCAPE) begin
                        remaining[c] = '0;
                        phase[c]     = PH_LONG0;
                    end else if (b < 8'd2) begin
                        phase[c] = PH_LOCKED;
                        expect_byte(c, 8'd0, 1'b1, ST_SHORT);
                    end else begin
                        remaining[c] = {24'd0, b};
                        phase[c]     = PH_PAYLOAD;
                    end
                end else if (ph >= PH_LONG0 && ph <= PH_LONG3) begin
                    k = int'(ph) - int'(PH_LONG0);
                    len = remaining[c] | ({24'd0, b} << (8 * k));
                    remaining[c] = len;
                    if (ph != PH_LONG3) begin
                        phase[c] = ph + 3'd1;
                    end else if (len[31] || len < 32'd2) begin
                        phase[c] = PH_LOCKED;
                        expect_byte(c, 8'd0, 1'b1, ST_LONG_SMALL);
                    end else if (len >= {7'd0, max_msg}) begin
                        phase[c] = PH_LOCKED;
                        expect_byte(c, 8'd0, 1'b1, ST_TOO_LARGE);
                    end else begin
                        phase[c] = PH_PAYLOAD;
                    end
                end else if (ph == PH_PAYLOAD) begin
                    if (remaining[c] <= 32'd1) begin
                        remaining[c] = '0;
                        phase[c]     = PH_LEN;
                        // frame done: saturating count, sticky overload, window restart
                        if (count[c] != COUNT_MAX)
                            count[c] = count[c] + 17'd1;
                        if (count[c] > {1'b0, limit_count}) begin
                            st = ST_OVERLOAD;
                        end else begin
                            st = ST_OK;
                            if (TIME_W'(now - win_start[c]) > window_ms) begin
                                win_start[c] = now;
                                count[c]     = '0;
                            end
                        end
                        expect_byte(c, b, 1'b1, st);
                    end else begin
                        remaining[c] = remaining[c] - 32'd1;
                        expect_byte(c, b, 1'b0, ST_OK);
                    end
                end
                // locked slot: byte is dropped
            end
        endfunction

        function void flag(string what, t_deframed_byte want, t_deframed_byte got);
            errors++;
            if (errors <= 10)
                $display({"%0t %s: exp conn=%0d byte=%02h last=%0b st=%0d, ",
                          "got conn=%0d byte=%02h last=%0b st=%0d"},
                         $realtime, what, want.conn, want.data, want.last, want.status,
                         got.conn, got.data, got.last, got.status);
        endfunction

        function void check_result(t_deframed_byte got);
            t_deframed_byte want;
            if (due_bytes.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = due_bytes.pop_front();
            if (want.conn !== got.conn || want.data !== got.data ||
                want.last !== got.last || want.status !== got.status)
                flag("wrong result", want, got);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;   // [5:0] conn, [13:6] data_byte, [45:14] now_ms
    logic [REQ_W-1:0]        s_axis_tuser;   // [1:0] req_type
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;   // [5:0] out_conn, [13:6] payload_byte
    logic                    m_axis_tlast;
    logic [STATUS_W-1:0]     m_axis_tuser;   // [2:0] status
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    deframe_scoreboard sb;
    logic [TIME_W-1:0] now_ms;
    logic [LEN_W-1:0]  long_len [64];
    logic [CONN_W-1:0] active_slot [8];
    int                snd_idle_pct;
    int                rcv_idle_pct;
    logic              hold_go;
    int                stall_cycles;

    length_prefixed_deframer_rate_limit_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // receiver: checks results and drives tready, with one long hold-off on request
    initial begin
        int hold_left;
        t_deframed_byte got;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.conn   = m_axis_tdata[5:0];
                got.data   = m_axis_tdata[13:6];
                got.last   = m_axis_tlast;
                got.status = m_axis_tuser;
                sb.check_result(got);
            end
            if (hold_left == 0 && hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("length_prefixed_deframer_rate_limit_top: mismatch");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [CONN_W-1:0] c,
                            input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, now_ms, b, c};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, c, b, now_ms);
    endtask

    // called right at an accept edge: stop offering and let the pipeline empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [TIME_W-1:0] win, input logic [LIMIT_W-1:0] lim,
                                input logic [MAXMSG_W-1:0] maxm);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WINDOW;
        i_cfg_data <= win;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= {16'd0, lim};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAXMSG;
        i_cfg_data <= {7'd0, maxm};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_config(win, lim, maxm);
    endtask

    // mostly well-formed frames on a few busy slots, plus noise and connection churn
    task automatic run_random(input int n, input int hold_at, input int drain_at);
        int                sent;
        int unsigned       roll;
        int unsigned       pick;
        logic [REQ_W-1:0]  req;
        logic [CONN_W-1:0] c;
        logic [BYTE_W-1:0] b;
        logic [PHASE_W-1:0] ph;
        sent = 0;
        for (int i = 0; i < 8; i++)
            active_slot[i] = CONN_W'($urandom_range(0, 63));
        while (sent < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                now_ms = now_ms + $urandom_range(1, 20);
            else if (roll < 27)
                now_ms = now_ms + $urandom_range(0, 6000);
            else if (roll < 29)
                now_ms = $urandom();

            roll = $urandom_range(0, 99);
            c    = active_slot[$urandom_range(0, 7)];
            b    = BYTE_W'($urandom());
            req  = REQ_BYTE;
            ph   = sb.phase[c];
            if (roll < 3) begin
                req = REQ_OPEN;
                if (roll == 0)
                    c = CONN_W'($urandom());
            end else if (roll < 5) begin
                req = REQ_CLOSE;
            end else if (roll < 6) begin
                req = REQ_UNUSED;
            end else if (roll < 12) begin
                c = CONN_W'($urandom());
            end else if (ph == PH_CLOSED || ph == PH_LOCKED) begin
                if (roll < 70)
                    req = REQ_OPEN;
            end else if (ph == PH_LEN) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    b = BYTE_W'($urandom_range(0, 1));
                end else if (pick < 4) begin
                    b = 8'd254;
                end else if (pick < 26) begin
                    b    = LEN_ESCAPE;
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                        long_len[c] = $urandom_range(2, 12);
                    else if (pick < 55)
                        long_len[c] = {7'd0, sb.max_msg};
                    else if (pick < 70)
                        long_len[c] = (sb.max_msg <= 25'd64) ? {7'd0, sb.max_msg} - 32'd1 : 32'd3;
                    else if (pick < 85)
                        long_len[c] = $urandom_range(0, 1);
                    else
                        long_len[c] = {1'b1, 31'($urandom())};
                end else begin
                    b = BYTE_W'($urandom_range(2, 9));
                end
            end else if (ph >= PH_LONG0 && ph <= PH_LONG3) begin
                b = BYTE_W'(long_len[c] >> (8 * (int'(ph) - int'(PH_LONG0))));
            end

            send_req(req, c, b);
            if (req != REQ_UNUSED) begin
                sent++;
                if (sent == hold_at)
                    hold_go = 1'b1;
                if (sent == drain_at)
                    wait_drained();
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_BYTE;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WINDOW;
        i_cfg_data    <= '0;
        hold_go       = 1'b0;
        stall_cycles  = 0;
        now_ms        = 32'hFFFF_FFFF;
        snd_idle_pct  = 16;
        rcv_idle_pct  = 78;
        for (int i = 0; i < 64; i++)
            long_len[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: closed slot, ignored type, short frame across time wrap, every length error
        send_req(REQ_BYTE, 6'd63, 8'hFF);
        send_req(REQ_UNUSED, 6'd0, 8'h00);
        send_req(REQ_OPEN, 6'd0, 8'h00);
        send_req(REQ_BYTE, 6'd0, 8'd2);
        send_req(REQ_BYTE, 6'd0, 8'h00);
        now_ms = 32'd0;
        send_req(REQ_BYTE, 6'd0, 8'hFF);
        send_req(REQ_OPEN, 6'd1, 8'h00);
        send_req(REQ_BYTE, 6'd1, 8'h00);
        send_req(REQ_BYTE, 6'd1, 8'hAA);      // locked, dropped
        send_req(REQ_OPEN, 6'd2, 8'h00);
        send_req(REQ_BYTE, 6'd2, LEN_ESCAPE);
        send_req(REQ_BYTE, 6'd2, 8'h02);
        send_req(REQ_BYTE, 6'd2, 8'h00);
        send_req(REQ_BYTE, 6'd2, 8'h00);
        send_req(REQ_BYTE, 6'd2, 8'h80);      // negative long length
        send_req(REQ_OPEN, 6'd3, 8'h00);
        send_req(REQ_BYTE, 6'd3, LEN_ESCAPE);
        send_req(REQ_BYTE, 6'd3, 8'h00);
        send_req(REQ_BYTE, 6'd3, 8'h00);
        send_req(REQ_BYTE, 6'd3, 8'h01);
        send_req(REQ_BYTE, 6'd3, 8'h00);      // exactly the size limit
        send_req(REQ_CLOSE, 6'd0, 8'h00);
        send_req(REQ_BYTE, 6'd0, 8'h55);

        write_config(32'd1, 16'd1, 25'd3);
        run_random(155, -1, -1);

        snd_idle_pct = 78;
        rcv_idle_pct = 16;
        write_config(32'hFFFF_FFFF, 16'hFFFF, 25'h100_0000);
        run_random(155, -1, 80);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_config(32'($urandom_range(20, 3000)), 16'd3, 25'd300);
        run_random(155, 40, -1);

        write_config(32'd50, 16'd2, 25'd40);
        run_random(155, -1, -1);

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("length_prefixed_deframer_rate_limit_top: match");
        else
            $display("length_prefixed_deframer_rate_limit_top: mismatch");
        $finish;
    end

endmodule
